>>> hw/rtl/bmhq_pkg.sv
// Shared types, sizes and codes for the binary min-heap queue.
// No dependencies; used by every module of the block.
`default_nettype none

package bmhq_pkg;

  localparam int DEPTH       = 512;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int COUNT_W     = $clog2(DEPTH + 1);
  localparam int POS_W       = $clog2(2 * DEPTH + 2);
  localparam int KEY_W       = 32;
  localparam int HANDLE_W    = 9;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = ((KEY_W + HANDLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((KEY_W + HANDLE_W + COUNT_W + 7) / 8) * 8;

  typedef enum logic [0:0] {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_POP_LD,
    S_DN_CHK,
    S_WR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } ram_wr_t;

  typedef struct packed {
    logic cur_gt_a;
    logic cur_gt_b;
    logic cur_lt_a;
    logic a_lt_b;
  } cmp_res_t;

  typedef struct packed {
    logic               valid;
    entry_t             entry;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } result_t;

  // heap positions are one-based, storage addresses zero-based
  function automatic logic [ADDR_W-1:0] pos_to_addr(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] p;
    p = pos - POS_W'(1);
    return p[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/binary_min_heap_queue_core.sv
// Top level of the binary min-heap queue: stream ports and result register.
// Depends on bmhq_pkg, bmhq_ram and bmhq_seq.
//
// Usage:
//   in_*  : one request per item. in_tuser is the function (0 push, 1 pop);
//           in_tdata carries the key and handle of an entry to push.
//   out_* : exactly one result per request, in request order. out_tuser is the
//           status (0 done, 1 pop on empty heap, 2 push on full heap); out_tdata
//           holds the popped key and handle (zero otherwise) and the entry count.
// Timing: a request walks the heap one level per cycle in a single shared
//   compare-and-move loop over a two-read, one-write entry store. A push into an
//   empty or full heap and a pop on an empty heap do not walk it. With 512
//   entries a push climbs at most 9 levels and a pop descends at most 8.
//   in_tready is high only while no request is in progress, so a new request
//   is taken only once the previous one has passed its result to the output register.
// Stall: the result sits in an output register; a new request may be taken
//   while it waits, but that request finishes only once the register drains.
// Reset: the heap is empty after reset; no clearing pass is needed.
`default_nettype none

module binary_min_heap_queue_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [bmhq_pkg::IN_TDATA_W-1:0]   in_tdata,  // entry_key, entry_handle
  input  wire logic                              in_tuser,  // func
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [bmhq_pkg::OUT_TDATA_W-1:0]       out_tdata, // out_key, out_handle, out_count
  output logic [bmhq_pkg::STATUS_W-1:0]          out_tuser  // status
);

  localparam int KW = bmhq_pkg::KEY_W;
  localparam int HW = bmhq_pkg::HANDLE_W;
  localparam int CW = bmhq_pkg::COUNT_W;

  bmhq_pkg::entry_t  req_entry;
  bmhq_pkg::func_t   req_func;
  bmhq_pkg::result_t res;
  bmhq_pkg::ram_wr_t ram_wr;
  bmhq_pkg::entry_t  rd_a, rd_b;
  logic [bmhq_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b;

  logic                             out_valid_r, out_valid_nxt;
  logic [bmhq_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [bmhq_pkg::STATUS_W-1:0]    out_user_r, out_user_nxt;
  logic                             res_free, res_load;

  assign req_entry = '{key: in_tdata[KW-1:0], handle: in_tdata[KW+HW-1:KW]};
  assign req_func  = bmhq_pkg::func_t'(in_tuser);

  bmhq_ram u_ram (
    .clk       (clk),
    .wr        (ram_wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  bmhq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_func  (req_func),
    .req_entry (req_entry),
    .res_free  (res_free),
    .res       (res),
    .ram_wr    (ram_wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  assign res_free = !out_valid_r || out_tready;
  assign res_load = res.valid && res_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[KW-1:0]          = res.entry.key;
      out_data_nxt[KW+HW-1:KW]      = res.entry.handle;
      out_data_nxt[KW+HW+CW-1:KW+HW] = res.count;
      out_user_nxt  = res.status;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

>>> hw/rtl/bmhq_ram.sv
// Heap entry storage: one write port, two registered read ports.
// Depends on bmhq_pkg for sizes and the entry type.
`default_nettype none

module bmhq_ram (
  input  wire logic                       clk,
  input  wire bmhq_pkg::ram_wr_t          wr,
  input  wire logic [bmhq_pkg::ADDR_W-1:0] rd_addr_a,
  input  wire logic [bmhq_pkg::ADDR_W-1:0] rd_addr_b,
  output bmhq_pkg::entry_t                rd_a,
  output bmhq_pkg::entry_t                rd_b
);

  bmhq_pkg::entry_t mem [bmhq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

>>> hw/rtl/bmhq_cmp.sv
// Shared key comparator used by both sift directions.
// Depends on bmhq_pkg for the key width and result struct.
`default_nettype none

module bmhq_cmp (
  input  wire logic [bmhq_pkg::KEY_W-1:0] cur_key,
  input  wire logic [bmhq_pkg::KEY_W-1:0] a_key,
  input  wire logic [bmhq_pkg::KEY_W-1:0] b_key,
  output bmhq_pkg::cmp_res_t              res
);

  always_comb begin
    res.cur_gt_a = cur_key > a_key;
    res.cur_gt_b = cur_key > b_key;
    res.cur_lt_a = cur_key < a_key;
    res.a_lt_b   = a_key < b_key;
  end

endmodule

`default_nettype wire

>>> hw/rtl/bmhq_seq.sv
// Sift sequencer: holds the moving entry, walks the heap one level a cycle.
// Depends on bmhq_pkg and bmhq_cmp; drives the storage ports of bmhq_ram.
`default_nettype none

module bmhq_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire bmhq_pkg::func_t             req_func,
  input  wire bmhq_pkg::entry_t            req_entry,
  input  wire logic                        res_free,
  output bmhq_pkg::result_t                res,
  output bmhq_pkg::ram_wr_t                ram_wr,
  output logic [bmhq_pkg::ADDR_W-1:0]      rd_addr_a,
  output logic [bmhq_pkg::ADDR_W-1:0]      rd_addr_b,
  input  wire bmhq_pkg::entry_t            rd_a,
  input  wire bmhq_pkg::entry_t            rd_b
);

  localparam int PW = bmhq_pkg::POS_W;
  localparam int CW = bmhq_pkg::COUNT_W;

  bmhq_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  bmhq_pkg::entry_t   cur_r, cur_nxt;
  bmhq_pkg::entry_t   res_r, res_nxt;
  bmhq_pkg::status_t  status_r, status_nxt;

  bmhq_pkg::cmp_res_t cmp;

  logic          req_fire, full, empty;
  logic [PW-1:0] push_pos, up_par, m_ext, dn_l, dn_r, dn_next, dn_next_l;
  logic [CW-1:0] pop_m;
  logic          up_swap, up_more, has_r, dn_go, dn_take_r, dn_more;

  bmhq_cmp u_cmp (
    .cur_key (cur_r.key),
    .a_key   (rd_a.key),
    .b_key   (rd_b.key),
    .res     (cmp)
  );

  assign req_ready = (state_r == bmhq_pkg::S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign full      = (count_r == CW'(bmhq_pkg::DEPTH));
  assign empty     = (count_r == '0);
  assign push_pos  = PW'(count_r) + PW'(1);
  assign pop_m     = count_r - CW'(1);

  assign up_par    = pos_r >> 1;
  assign up_swap   = cmp.cur_lt_a;
  assign up_more   = (up_par > PW'(1));

  assign m_ext     = PW'(count_r);
  assign dn_l      = pos_r << 1;
  assign dn_r      = dn_l + PW'(1);
  assign has_r     = (dn_r <= m_ext);
  assign dn_go     = cmp.cur_gt_a || (has_r && cmp.cur_gt_b);
  assign dn_take_r = has_r && !cmp.a_lt_b;
  assign dn_next   = dn_take_r ? dn_r : dn_l;
  assign dn_next_l = dn_next << 1;
  assign dn_more   = (dn_next_l <= m_ext);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmhq_pkg::S_IDLE: begin
        if (req_fire) begin
          if (req_func == bmhq_pkg::FUNC_PUSH) begin
            if (full || push_pos == PW'(1)) begin
              state_nxt = bmhq_pkg::S_FIN;
            end else begin
              state_nxt = bmhq_pkg::S_UP_CHK;
            end
          end else begin
            state_nxt = empty ? bmhq_pkg::S_FIN : bmhq_pkg::S_POP_LD;
          end
        end
      end
      bmhq_pkg::S_UP_CHK: begin
        if (!up_swap) begin
          state_nxt = bmhq_pkg::S_FIN;
        end else if (!up_more) begin
          state_nxt = bmhq_pkg::S_WR;
        end
      end
      bmhq_pkg::S_POP_LD: begin
        if (pop_m == '0) begin
          state_nxt = bmhq_pkg::S_FIN;
        end else if (pop_m == CW'(1)) begin
          state_nxt = bmhq_pkg::S_WR;
        end else begin
          state_nxt = bmhq_pkg::S_DN_CHK;
        end
      end
      bmhq_pkg::S_DN_CHK: begin
        if (!dn_go) begin
          state_nxt = bmhq_pkg::S_FIN;
        end else if (!dn_more) begin
          state_nxt = bmhq_pkg::S_WR;
        end
      end
      bmhq_pkg::S_WR: state_nxt = bmhq_pkg::S_FIN;
      bmhq_pkg::S_FIN: begin
        if (res_free) begin
          state_nxt = bmhq_pkg::S_IDLE;
        end
      end
      default: state_nxt = bmhq_pkg::S_IDLE;
    endcase
  end

  // datapath and storage requests
  always_comb begin
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    cur_nxt    = cur_r;
    res_nxt    = res_r;
    status_nxt = status_r;
    ram_wr     = '0;
    rd_addr_a  = '0;
    rd_addr_b  = '0;
    unique case (state_r)
      bmhq_pkg::S_IDLE: begin
        if (req_func == bmhq_pkg::FUNC_PUSH) begin
          rd_addr_a = bmhq_pkg::pos_to_addr(push_pos >> 1);
        end else begin
          rd_addr_a = '0;
          rd_addr_b = bmhq_pkg::pos_to_addr(m_ext);
        end
        if (req_fire) begin
          res_nxt    = '0;
          status_nxt = bmhq_pkg::ST_DONE;
          if (req_func == bmhq_pkg::FUNC_PUSH) begin
            if (full) begin
              status_nxt = bmhq_pkg::ST_FULL;
            end else begin
              count_nxt = count_r + CW'(1);
              pos_nxt   = push_pos;
              cur_nxt   = req_entry;
              if (push_pos == PW'(1)) begin
                ram_wr = '{en: 1'b1, addr: '0, data: req_entry};
              end
            end
          end else if (empty) begin
            status_nxt = bmhq_pkg::ST_EMPTY;
          end
        end
      end
      bmhq_pkg::S_UP_CHK: begin
        rd_addr_a = bmhq_pkg::pos_to_addr(up_par >> 1);
        if (up_swap) begin
          ram_wr  = '{en: 1'b1, addr: bmhq_pkg::pos_to_addr(pos_r), data: rd_a};
          pos_nxt = up_par;
        end else begin
          ram_wr  = '{en: 1'b1, addr: bmhq_pkg::pos_to_addr(pos_r), data: cur_r};
        end
      end
      bmhq_pkg::S_POP_LD: begin
        rd_addr_a = bmhq_pkg::pos_to_addr(PW'(2));
        rd_addr_b = bmhq_pkg::pos_to_addr(PW'(3));
        res_nxt   = rd_a;
        cur_nxt   = rd_b;
        count_nxt = pop_m;
        pos_nxt   = PW'(1);
      end
      bmhq_pkg::S_DN_CHK: begin
        rd_addr_a = bmhq_pkg::pos_to_addr(dn_next_l);
        rd_addr_b = bmhq_pkg::pos_to_addr(dn_next_l + PW'(1));
        if (dn_go) begin
          ram_wr  = '{en: 1'b1, addr: bmhq_pkg::pos_to_addr(pos_r),
                      data: (dn_take_r ? rd_b : rd_a)};
          pos_nxt = dn_next;
        end else begin
          ram_wr  = '{en: 1'b1, addr: bmhq_pkg::pos_to_addr(pos_r), data: cur_r};
        end
      end
      bmhq_pkg::S_WR: begin
        ram_wr = '{en: 1'b1, addr: bmhq_pkg::pos_to_addr(pos_r), data: cur_r};
      end
      bmhq_pkg::S_FIN: ;
      default: ;
    endcase
  end

  assign res = '{valid: (state_r == bmhq_pkg::S_FIN), entry: res_r,
                 status: status_r, count: count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmhq_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    cur_r    <= cur_nxt;
    res_r    <= res_nxt;
    status_r <= status_nxt;
  end

endmodule

`default_nettype wire

>>> bench/tb_binary_min_heap_queue_core.sv
// Self-checking bench for binary_min_heap_queue_core: push and pop requests against
// a mirrored heap in a small scoreboard class, with bursty input and a stalling sink.
// Depends on bmhq_pkg and the block's RTL only.
`default_nettype none

module tb_binary_min_heap_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bmhq_pkg::*;

  localparam int ITEM_TARGET = 1350;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    status_t             status;
    logic [COUNT_W-1:0]  count;
  } heap_reply_t;

  class heap_mirror;
    logic [KEY_W-1:0]    keys    [1:DEPTH];
    logic [HANDLE_W-1:0] handles [1:DEPTH];
    int                  fill;
    int                  errors;
    heap_reply_t         pending [$];

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endfunction

    function void swap_pos(int a, int b);
      logic [KEY_W-1:0]    k;
      logic [HANDLE_W-1:0] h;
      k = keys[a];
      h = handles[a];
      keys[a] = keys[b];
      handles[a] = handles[b];
      keys[b] = k;
      handles[b] = h;
    endfunction

    function void sift_down();
      int  pos, l, r, nxt;
      bit  has_l, has_r;
      pos = 1;
      forever begin
        l = 2 * pos;
        r = l + 1;
        has_l = l <= fill;
        has_r = r <= fill;
        if (!((has_l && keys[pos] > keys[l]) || (has_r && keys[pos] > keys[r]))) break;
        // ties go to the right child
        nxt = (has_r && !(keys[l] < keys[r])) ? r : l;
        swap_pos(pos, nxt);
        pos = nxt;
      end
    endfunction

    function void note_request(func_t f, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
      heap_reply_t rep;
      int          pos;
      rep = '0;
      rep.status = ST_DONE;
      if (f == FUNC_PUSH) begin
        if (fill >= DEPTH) begin
          rep.status = ST_FULL;
        end else begin
          fill++;
          keys[fill] = k;
          handles[fill] = h;
          pos = fill;
          while (pos > 1 && keys[pos / 2] > keys[pos]) begin
            swap_pos(pos / 2, pos);
            pos = pos / 2;
          end
        end
      end else if (fill == 0) begin
        rep.status = ST_EMPTY;
      end else begin
        rep.key = keys[1];
        rep.handle = handles[1];
        keys[1] = keys[fill];
        handles[1] = handles[fill];
        fill--;
        sift_down();
      end
      rep.count = COUNT_W'(fill);
      pending.push_back(rep);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d, logic [STATUS_W-1:0] u);
      heap_reply_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending, tdata %h tuser %h", d, u));
        return;
      end
      want = pending.pop_front();
      if (d[KEY_W-1:0] !== want.key)
        report($sformatf("key got %h want %h", d[KEY_W-1:0], want.key));
      if (d[KEY_W +: HANDLE_W] !== want.handle)
        report($sformatf("handle got %h want %h", d[KEY_W +: HANDLE_W], want.handle));
      if (d[KEY_W+HANDLE_W +: COUNT_W] !== want.count)
        report($sformatf("count got %0d want %0d", d[KEY_W+HANDLE_W +: COUNT_W], want.count));
      if (u !== want.status)
        report($sformatf("status got %0d want %0d", u, want.status));
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  heap_mirror mirror;
  int         burst_left = 0;
  int         items_sent = 0;
  logic       hold_req   = 1'b0;
  int         hold_left  = 0;
  int         sink_mode  = 0;
  int         mode_left  = 0;

  binary_min_heap_queue_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("[binary_min_heap_queue_core] ERROR");
    $finish;
  end

  // sink: checks each accepted result, then picks the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) mirror.check_result(out_tdata, out_tuser);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (sink_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 15);
      2: return ($urandom_range(0, 1) == 1) ? '1 : '0;
      default: return $urandom_range(0, 100000);
    endcase
  endfunction

  task automatic offer(func_t f, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= IN_TDATA_W'({h, k});
    do @(posedge clk); while (!in_tready);
    mirror.note_request(f, k, h);
    items_sent++;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic random_item(int push_pct);
    func_t f;
    f = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
    offer(f, rand_key(), HANDLE_W'($urandom_range(0, 511)));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    mirror = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pop on empty, extreme keys and handles, equal keys, pop of last entry
    offer(FUNC_POP, '1, '1);
    offer(FUNC_PUSH, '0, '0);
    offer(FUNC_PUSH, '1, '1);
    offer(FUNC_PUSH, 32'd5, 9'd1);
    offer(FUNC_PUSH, 32'd5, 9'd2);
    offer(FUNC_PUSH, 32'd5, 9'd3);
    offer(FUNC_PUSH, '1, 9'd7);
    offer(FUNC_PUSH, 32'd1, 9'd100);
    offer(FUNC_PUSH, 32'h8000_0000, 9'h100);
    repeat (8) offer(FUNC_POP, rand_key(), HANDLE_W'($urandom_range(0, 511)));
    offer(FUNC_POP, '0, '0);
    offer(FUNC_PUSH, 32'h0000_0042, 9'h0AA);
    offer(FUNC_POP, '0, '0);
    wait_drained();

    // fill to the top, then keep pushing, with some pops, at or near full
    while (mirror.fill < DEPTH) random_item(95);
    repeat (25) random_item(80);
    wait_drained();

    // long sink stall while requests keep coming
    hold_req <= 1'b1;
    repeat (100) random_item(50);

    while (mirror.fill > 0) random_item(10);
    repeat (30) random_item(30);
    wait_drained();

    while (items_sent < ITEM_TARGET) random_item(55);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("[binary_min_heap_queue_core] OK");
    end else begin
      $display("[binary_min_heap_queue_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
